>>> src/itpc_pkg.sv
`timescale 1ns / 1ps

package itpc_pkg;

   localparam int FUNC_W    = 3;
   localparam int OPERAND_W = 64;
   localparam int CODE_W    = 8;
   localparam int RANK_W    = 3;
   localparam int KIND_W    = 2;
   localparam int ENTRY_W   = CODE_W + RANK_W;

   localparam logic [FUNC_W-1:0] FUNC_OPERAND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPEN    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_OPER    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_END     = 3'd4;

   localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

   localparam logic [CODE_W-1:0] OPEN_PAREN_CODE = 8'h28;
   localparam logic [RANK_W-1:0] PAREN_RANK      = 3'd0;
   localparam logic [RANK_W-1:0] MIN_OP_RANK     = 3'd1;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [OPERAND_W-1:0] operand_value;
      logic [CODE_W-1:0]    op_code;
      logic [RANK_W-1:0]    op_rank;
   } itpc_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]    out_kind;
      logic [OPERAND_W-1:0] out_operand;
      logic [CODE_W-1:0]    out_op_code;
      logic                 last;
   } itpc_rsp_type;

endpackage

>>> src/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. One token is taken per transfer on req_;
// postfix items leave on rsp_ through an output register, at most one per cycle, the last
// one of each token flagged by last. The block takes no new token until the current one is
// finished. Each token is taken in idle and then decided on; every stacked entry it
// examines adds a fetch and an examine state (the operator stack is a single-port memory
// with a registered read), and a push or the overflow error it turns into, an error or done
// transfer, and the last operator popped when the stack runs empty each add a state of
// their own. A stalled output holds back any state that must emit until the stall ends.
// No clearing pass after reset.
module infix_to_postfix_converter_top
   import itpc_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  itpc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output itpc_rsp_type rsp_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_EXAM   = 3'd3;
   localparam logic [2:0] S_FLUSH  = 3'd4;
   localparam logic [2:0] S_PUSH   = 3'd5;
   localparam logic [2:0] S_ERR    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      paren_ff, paren_in;
   logic               err_ff, err_in;
   itpc_req_type       tok_ff, tok_in;
   logic               held_valid_ff, held_valid_in;
   logic [CODE_W-1:0]  held_code_ff, held_code_in;
   logic [ENTRY_W-1:0] rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   itpc_rsp_type       rsp_ff, rsp_in;

   logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic               mem_re;
   logic [CW-1:0]      cnt_m1;
   logic [AW-1:0]      mem_ra;

   logic               slot_free;
   logic               emit;
   itpc_rsp_type       emit_data;
   logic [RANK_W-1:0]  rank_eff;
   logic [RANK_W-1:0]  top_rank;
   logic               term;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1    = cnt_ff - ONE_C;
   assign mem_ra    = cnt_m1[AW-1:0];
   assign rank_eff  = (tok_ff.op_rank == PAREN_RANK) ? MIN_OP_RANK : tok_ff.op_rank;
   assign top_rank  = rd_ff[ENTRY_W-1:CODE_W];

   always_comb begin
      case (tok_ff.func)
         FUNC_CLOSE: term = (top_rank == PAREN_RANK);
         FUNC_OPER:  term = (top_rank < rank_eff);
         default:    term = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      paren_in      = paren_ff;
      err_in        = err_ff;
      tok_in        = tok_ff;
      held_valid_in = held_valid_ff;
      held_code_in  = held_code_ff;
      emit          = 1'b0;
      emit_data     = '0;
      mem_we        = 1'b0;
      mem_wa        = cnt_ff[AW-1:0];
      mem_wd        = '0;
      mem_re        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tok_in   = req_data;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            held_valid_in = 1'b0;
            if (tok_ff.func == FUNC_END) begin
               if (err_ff || cnt_ff == '0) begin
                  state_in = S_DONE;
               end else if (paren_ff != '0) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_FETCH;
               end
            end else if (err_ff) begin
               state_in = S_IDLE;
            end else begin
               case (tok_ff.func)
                  FUNC_OPERAND: begin
                     if (slot_free) begin
                        emit                  = 1'b1;
                        emit_data.out_kind    = KIND_OPERAND;
                        emit_data.out_operand = tok_ff.operand_value;
                        emit_data.last        = 1'b1;
                        state_in              = S_IDLE;
                     end
                  end
                  FUNC_OPEN:  state_in = S_PUSH;
                  FUNC_CLOSE: state_in = (paren_ff == '0) ? S_ERR : S_FETCH;
                  FUNC_OPER:  state_in = (cnt_ff == '0) ? S_PUSH : S_FETCH;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_FETCH: begin
            mem_re   = 1'b1;
            state_in = S_EXAM;
         end
         S_EXAM: begin
            if (!held_valid_ff || slot_free) begin
               emit                  = held_valid_ff;
               emit_data.out_kind    = KIND_OPERATOR;
               emit_data.out_op_code = held_code_ff;
               if (term) begin
                  emit_data.last = 1'b1;
                  held_valid_in  = 1'b0;
                  if (tok_ff.func == FUNC_CLOSE) begin
                     cnt_in   = cnt_m1;
                     paren_in = paren_ff - ONE_C;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_PUSH;
                  end
               end else begin
                  held_valid_in = 1'b1;
                  held_code_in  = rd_ff[CODE_W-1:0];
                  cnt_in        = cnt_m1;
                  state_in      = (cnt_ff == ONE_C) ? S_FLUSH : S_FETCH;
               end
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               emit                  = 1'b1;
               emit_data.out_kind    = KIND_OPERATOR;
               emit_data.out_op_code = held_code_ff;
               emit_data.last        = (tok_ff.func == FUNC_OPER);
               held_valid_in         = 1'b0;
               state_in              = (tok_ff.func == FUNC_OPER) ? S_PUSH : S_DONE;
            end
         end
         S_PUSH: begin
            if (cnt_ff >= DEPTH_C) begin
               if (slot_free) begin
                  emit               = 1'b1;
                  emit_data.out_kind = KIND_ERROR;
                  emit_data.last     = 1'b1;
                  cnt_in             = '0;
                  paren_in           = '0;
                  err_in             = 1'b1;
                  state_in           = S_IDLE;
               end
            end else begin
               mem_we   = 1'b1;
               mem_wd   = (tok_ff.func == FUNC_OPEN) ? {PAREN_RANK, OPEN_PAREN_CODE}
                                                     : {rank_eff, tok_ff.op_code};
               cnt_in   = cnt_ff + ONE_C;
               paren_in = (tok_ff.func == FUNC_OPEN) ? paren_ff + ONE_C : paren_ff;
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               emit               = 1'b1;
               emit_data.out_kind = KIND_ERROR;
               emit_data.last     = (tok_ff.func != FUNC_END);
               cnt_in             = '0;
               paren_in           = '0;
               err_in             = 1'b1;
               state_in           = (tok_ff.func == FUNC_END) ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               emit               = 1'b1;
               emit_data.out_kind = KIND_DONE;
               emit_data.last     = 1'b1;
               cnt_in             = '0;
               paren_in           = '0;
               err_in             = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= stack_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         paren_ff      <= '0;
         err_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         paren_ff      <= paren_in;
         err_ff        <= err_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff       <= tok_in;
      held_code_ff <= held_code_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/itpc_checker.sv
`timescale 1ns / 1ps

module itpc_checker
   import itpc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input itpc_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input itpc_rsp_type rsp_data
);

   // one token in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("token accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_kind == KIND_OPERAND || rsp_data.out_kind == KIND_DONE))
      |-> rsp_data.last)
      else $error("operand or done transfer without last");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind != KIND_OPERAND) |-> (rsp_data.out_operand == '0))
      else $error("operand field set on non-operand result");

endmodule

bind infix_to_postfix_converter_top itpc_checker u_itpc_checker (.*);
